FILE: sv/elct_pkg.sv
// Package for the extent-list cluster translator.
// Holds the shared sizes, opcodes, FSM state type and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package elct_pkg;

	localparam int MaxExtents = 16;
	localparam int IdxW       = $clog2(MaxExtents);
	localparam int CntW       = 5;
	localparam int ClusterW   = 32;
	localparam int LenW       = 16;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ADDR_EXTENT_COUNT = 2'b00;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr;        // store one extent entry
		logic load;      // start a lookup
		logic step;      // advance to the next entry
		logic emit_hit;  // deliver the current entry as a match
		logic emit_miss; // deliver a not-found result
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic empty; // no entries in use
		logic hit;   // current entry covers the virtual cluster
		logic last;  // current entry is the last one in use
	} status_t;

endpackage

`default_nettype wire

FILE: sv/extent_list_cluster_translate.sv
// Top level of the extent-list cluster translator.
// Holds the APB register and ties elct_ctrl to elct_dp; depends on elct_pkg.
//
// A write item (opcode 0) stores one extent and leaves busy low. A lookup
// (opcode 1) walks the first extent_count entries (saturated at 16), one entry
// per clock through a single compare and subtract, and raises done for exactly
// one cycle with the result in the cycle after the matching or last entry,
// busy high throughout the walk. The receiver cannot stall; done must be
// sampled when it is high. extent_count is written over APB at address 0, and
// the user must do so only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module extent_list_cluster_translate import elct_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                opcode,
	input  wire logic [IdxW-1:0]     entry_index,
	input  wire logic [ClusterW-1:0] entry_start,
	input  wire logic [LenW-1:0]     entry_length,
	input  wire logic [ClusterW-1:0] virtual_cluster,
	output logic                     done,
	output logic [ClusterW-1:0]      logical_cluster,
	output logic                     found
);

	logic [CntW-1:0] extent_count_q;
	cmd_t            cmd;
	status_t         status;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_EXTENT_COUNT) ? {{(32-CntW){1'b0}}, extent_count_q} : '0;

	// Write the entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_count_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_EXTENT_COUNT) begin
			extent_count_q <= pwdata[CntW-1:0];
		end
	end

	elct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	elct_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.entry_index     (entry_index),
		.entry_start     (entry_start),
		.entry_length    (entry_length),
		.virtual_cluster (virtual_cluster),
		.extent_count    (extent_count_q),
		.logical_cluster (logical_cluster),
		.found           (found),
		.done            (done)
	);

endmodule

`default_nettype wire

FILE: sv/elct_ctrl.sv
// Controller FSM for the extent-list cluster translator.
// Sequences the entry walk; depends on elct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module elct_ctrl import elct_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    opcode,
	input  wire status_t status,
	output cmd_t         cmd,
	output logic         busy
);

	state_t state_q;
	state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && opcode == OP_LOOKUP) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.empty || status.hit || status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr   = start && opcode == OP_WRITE;
				cmd.load = start && opcode == OP_LOOKUP;
			end
			ST_WALK: begin
				busy = 1'b1;
				priority if (status.empty) begin
					cmd.emit_miss = 1'b1;
				end else if (status.hit) begin
					cmd.emit_hit = 1'b1;
				end else if (status.last) begin
					cmd.emit_miss = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/elct_dp.sv
// Datapath for the extent-list cluster translator.
// Holds the extent table, the walk index, the remaining offset and the result
// registers; depends on elct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module elct_dp import elct_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output status_t                  status,
	input  wire logic [IdxW-1:0]     entry_index,
	input  wire logic [ClusterW-1:0] entry_start,
	input  wire logic [LenW-1:0]     entry_length,
	input  wire logic [ClusterW-1:0] virtual_cluster,
	input  wire logic [CntW-1:0]     extent_count,
	output logic [ClusterW-1:0]      logical_cluster,
	output logic                     found,
	output logic                     done
);

	logic [ClusterW-1:0] start_tbl_q [MaxExtents];
	logic [LenW-1:0]     len_tbl_q   [MaxExtents];
	logic [IdxW-1:0]     idx_q;
	logic [ClusterW-1:0] rem_q;   // virtual cluster minus lengths walked so far
	logic [CntW-1:0]     eff_cnt;
	logic [LenW-1:0]     cur_len;
	logic [ClusterW-1:0] cur_start;
	logic [CntW-1:0]     idx_next;

	// Saturate the entry count at the table size
	assign eff_cnt = (extent_count > CntW'(MaxExtents)) ? CntW'(MaxExtents) : extent_count;

	assign cur_len   = len_tbl_q[idx_q];
	assign cur_start = start_tbl_q[idx_q];
	assign idx_next  = {1'b0, idx_q} + CntW'(1);

	// Entry matches when its length reaches past the remaining offset
	assign status.empty = eff_cnt == '0;
	assign status.hit   = {{(ClusterW-LenW){1'b0}}, cur_len} > rem_q;
	assign status.last  = idx_next == eff_cnt;

	// Store one extent entry
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			start_tbl_q[entry_index] <= entry_start;
			len_tbl_q[entry_index]   <= entry_length;
		end
	end

	// Advance the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_next[IdxW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= virtual_cluster;
		end else if (cmd.step) begin
			rem_q <= rem_q - {{(ClusterW-LenW){1'b0}}, cur_len};
		end
	end

	// Drive the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit_hit || cmd.emit_miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hit) begin
			logical_cluster <= cur_start + rem_q;
			found           <= 1'b1;
		end else if (cmd.emit_miss) begin
			logical_cluster <= '0;
			found           <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: tb/extent_list_cluster_translate_tb.sv
// Self-checking testbench for extent_list_cluster_translate.
// Drives write and lookup items, programs extent_count over APB, and checks each
// lookup result against an in-bench extent walk; depends on elct_pkg and the RTL.
`timescale 1ns / 1ps

module extent_list_cluster_translate_tb;
	import elct_pkg::*;

	typedef struct {
		logic                op;
		logic [IdxW-1:0]     idx;
		logic [ClusterW-1:0] first;
		logic [LenW-1:0]     len;
		logic [ClusterW-1:0] vcn;
	} extent_cmd_t;

	typedef struct {
		logic [ClusterW-1:0] cluster;
		logic                hit;
	} translation_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [1:0]          paddr = ADDR_EXTENT_COUNT;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                start = 1'b0;
	logic                busy;
	logic                opcode = OP_WRITE;
	logic [IdxW-1:0]     entry_index = '0;
	logic [ClusterW-1:0] entry_start = '0;
	logic [LenW-1:0]     entry_length = '0;
	logic [ClusterW-1:0] virtual_cluster = '0;
	logic                done;
	logic [ClusterW-1:0] logical_cluster;
	logic                found;

	// Extent table as the block should hold it, plus the active count
	logic [ClusterW-1:0] table_first [MaxExtents];
	logic [LenW-1:0]     table_len [MaxExtents];
	logic [CntW-1:0]     active_count = '0;
	// Lengths as they will stand once every queued item is taken
	logic [LenW-1:0]     queued_len [MaxExtents];

	extent_cmd_t  cmd_queue [$];
	translation_t expected_translations [$];

	int  mismatch_count = 0;
	int  accepted_count = 0;
	int  lookup_count = 0;
	int  hit_count = 0;
	int  setting_count = 0;
	int  gap_left = 0;
	bit  steady = 1'b0;

	extent_list_cluster_translate uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .opcode(opcode), .entry_index(entry_index),
		.entry_start(entry_start), .entry_length(entry_length),
		.virtual_cluster(virtual_cluster),
		.done(done), .logical_cluster(logical_cluster), .found(found)
	);

	always #4 clk = ~clk;

	// Walk the active extents and translate one virtual cluster
	function automatic translation_t translate_cluster(input logic [ClusterW-1:0] vcn);
		translation_t t;
		logic [ClusterW-1:0] sum;
		logic [ClusterW-1:0] base;
		int n;
		t.cluster = '0;
		t.hit = 1'b0;
		sum = '0;
		n = (active_count > MaxExtents) ? MaxExtents : active_count;
		for (int i = 0; i < n; i++) begin
			base = sum;
			sum = sum + table_len[i];
			if (sum > vcn) begin
				t.cluster = table_first[i] + (vcn - base);
				t.hit = 1'b1;
				break;
			end
		end
		return t;
	endfunction

	// Sum of the queued lengths of the first n slots
	function automatic logic [ClusterW-1:0] queued_prefix(input int n);
		logic [ClusterW-1:0] sum;
		sum = '0;
		for (int i = 0; i < n; i++)
			sum = sum + queued_len[i];
		return sum;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: present queued items, hold until accepted, insert random gaps
	always @(posedge clk) begin
		extent_cmd_t c;
		translation_t t;
		bit taken;
		if (arst_n) begin
			taken = start && !busy;
			if (taken) begin
				accepted_count++;
				if (opcode == OP_WRITE) begin
					table_first[entry_index] = entry_start;
					table_len[entry_index] = entry_length;
				end else begin
					t = translate_cluster(virtual_cluster);
					expected_translations.push_back(t);
					lookup_count++;
					if (t.hit)
						hit_count++;
				end
				gap_left = pick_gap();
			end
			if (start && !taken) begin
				// hold the item
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				c = cmd_queue.pop_front();
				opcode <= c.op;
				entry_index <= c.idx;
				entry_start <= c.first;
				entry_length <= c.len;
				virtual_cluster <= c.vcn;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check each result against the oldest expectation
	always @(posedge clk) begin
		translation_t e;
		if (arst_n && done) begin
			if (expected_translations.size() == 0) begin
				$display("%0t: unexpected result cluster=%h found=%b",
					$time, logical_cluster, found);
				mismatch_count++;
			end else begin
				e = expected_translations.pop_front();
				if (logical_cluster !== e.cluster) begin
					$display("%0t: logical_cluster expected %h actual %h",
						$time, e.cluster, logical_cluster);
					mismatch_count++;
				end
				if (found !== e.hit) begin
					$display("%0t: found expected %b actual %b", $time, e.hit, found);
					mismatch_count++;
				end
			end
		end
	end

	task automatic push_write(input int idx, input logic [ClusterW-1:0] first,
			input logic [LenW-1:0] len);
		extent_cmd_t c;
		c.op = OP_WRITE;
		c.idx = IdxW'(idx);
		c.first = first;
		c.len = len;
		c.vcn = $urandom;
		queued_len[idx] = len;
		cmd_queue.push_back(c);
	endtask

	task automatic push_lookup(input logic [ClusterW-1:0] vcn);
		extent_cmd_t c;
		c.op = OP_LOOKUP;
		c.idx = IdxW'($urandom);
		c.first = $urandom;
		c.len = LenW'($urandom);
		c.vcn = vcn;
		cmd_queue.push_back(c);
	endtask

	// Lookup mostly inside an active extent, some near the end, some anywhere
	task automatic push_random_lookup();
		int n;
		int j;
		int roll;
		logic [ClusterW-1:0] vcn;
		n = (active_count > MaxExtents) ? MaxExtents : active_count;
		roll = $urandom_range(0, 99);
		if (n > 0 && roll < 70) begin
			j = $urandom_range(0, n - 1);
			vcn = queued_prefix(j);
			if (queued_len[j] != 0)
				vcn = vcn + $urandom_range(0, queued_len[j] - 1);
		end else if (roll < 88) begin
			vcn = queued_prefix(n) + $urandom_range(0, 2) - 1;
		end else begin
			vcn = $urandom;
		end
		push_lookup(vcn);
	endtask

	task automatic push_random_write();
		int roll;
		logic [LenW-1:0] len;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			len = '0;
		else if (roll < 30)
			len = '1;
		else if (roll < 70)
			len = LenW'($urandom_range(1, 64));
		else
			len = LenW'($urandom);
		push_write($urandom_range(0, MaxExtents - 1), $urandom, len);
	endtask

	// Wait until every item is taken and every result is back, then settle
	task automatic drain();
		do @(posedge clk);
		while (cmd_queue.size() > 0 || start || expected_translations.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_extent_count(input logic [CntW-1:0] cnt);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_EXTENT_COUNT;
		pwdata <= {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, cnt};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		active_count = cnt;
		setting_count++;
		// read the register back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata[CntW-1:0] !== active_count) begin
			$display("%0t: extent_count readback expected %h actual %h",
				$time, active_count, prdata[CntW-1:0]);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int counts [10] = '{16, 1, 31, 17, 0, 8, 16, 2, 20, 15};
		logic [ClusterW-1:0] total;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table in use: lookups miss
		push_lookup('0);
		push_lookup('1);
		// Fill every slot: zero start, wrapping start, zero and full lengths
		push_write(0, '0, 16'd5);
		push_write(1, 32'hFFFF_FFF8, 16'h0010);
		push_write(2, 32'h1234_5678, '0);
		push_write(3, 32'h8000_0000, '1);
		for (int i = 4; i < MaxExtents; i++)
			push_write(i, $urandom, LenW'($urandom_range(1, 300)));
		drain();

		// Full table: boundaries, wrap, zero-length skip, past the end
		set_extent_count(CntW'(MaxExtents));
		total = queued_prefix(MaxExtents);
		push_lookup('0);
		push_lookup(32'd5);
		push_lookup(32'd20);
		push_lookup(32'd21);
		push_lookup(total - 1);
		push_lookup(total);
		push_lookup('1);
		drain();

		// Random phases across count settings, saturated values included
		for (int p = 0; p < 10; p++) begin
			set_extent_count(CntW'(counts[p]));
			steady = (p % 3 == 2);
			for (int k = 0; k < 98; k++) begin
				if ($urandom_range(0, 99) < 20)
					push_random_write();
				else
					push_random_lookup();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (expected_translations.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_translations.size());
			mismatch_count++;
		end
		$display("Covered %0d items, %0d lookups (%0d hits, %0d misses), %0d count settings",
			accepted_count, lookup_count, hit_count, lookup_count - hit_count, setting_count);
		if (mismatch_count == 0)
			$display("extent_list_cluster_translate_tb: clean");
		else
			$display("extent_list_cluster_translate_tb: errors");
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#5ms;
		$display("%0t: timeout", $time);
		$display("extent_list_cluster_translate_tb: errors");
		$finish;
	end

endmodule

FILE: filelist.f
sv/elct_pkg.sv
sv/elct_ctrl.sv
sv/elct_dp.sv
sv/extent_list_cluster_translate.sv
tb/extent_list_cluster_translate_tb.sv
